// ===== hw/rtl/rpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// RC pulse width decoder package
// Shared constants, codes and structs for the pulse width decoder.
// ----------------------------------------------------------------------------
package rpwd_pkg;

	// Channel counts
	localparam int NUM_CHANNELS = 8;
	localparam int NUM_SERVOS   = 6;

	// Field widths
	localparam int KIND_W  = 2;
	localparam int CHAN_W  = 3;
	localparam int PULSE_W = 16;
	localparam int MS_W    = 32;
	localparam int CFG_W   = 16;

	// Register reset values
	localparam logic [CFG_W-1:0] TIMEOUT_MS_RST = 16'd50;
	localparam logic [CFG_W-1:0] FAILSAFE_RST   = 16'd1500;

	// Input item kinds; the fourth code is unused and ignored.
	typedef enum logic [KIND_W-1:0] {
		KIND_EDGE = 2'd0,
		KIND_TICK = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	// Result item kinds
	typedef enum logic {
		REPLY_SERVO = 1'b0,
		REPLY_READ  = 1'b1
	} reply_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_TIMEOUT  = 1'b0,
		CFG_FAILSAFE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CHAN_W-1:0]  channel;
		logic [PULSE_W-1:0] capture_value;
	} item_t;

	typedef struct packed {
		logic               reply_kind;
		logic [CHAN_W-1:0]  target_index;
		logic [PULSE_W-1:0] pulse_value;
	} result_t;

endpackage

// ===== hw/rtl/rpwd_if.sv =====
// ----------------------------------------------------------------------------
// RC pulse width decoder channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rpwd_in_if;
	logic                        valid;
	logic                        ready;
	logic [rpwd_pkg::KIND_W-1:0]  kind;
	logic [rpwd_pkg::CHAN_W-1:0]  channel;
	logic [rpwd_pkg::PULSE_W-1:0] capture_value;

	modport source(output valid, output kind, output channel, output capture_value,
		input ready);
	modport sink(input valid, input kind, input channel, input capture_value,
		output ready);
endinterface

interface rpwd_out_if;
	logic                        valid;
	logic                        ready;
	logic                        reply_kind;
	logic [rpwd_pkg::CHAN_W-1:0]  target_index;
	logic [rpwd_pkg::PULSE_W-1:0] pulse_value;

	modport source(output valid, output reply_kind, output target_index,
		output pulse_value, input ready);
	modport sink(input valid, input reply_kind, input target_index,
		input pulse_value, output ready);
endinterface

// ===== hw/rtl/rpwd_chan_regs.sv =====
// ----------------------------------------------------------------------------
// RC pulse width decoder channel register file
// Holds the millisecond clock and per-channel pulse state, and works out the
// result of the item in the input register.
// ----------------------------------------------------------------------------
module rpwd_chan_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  rpwd_pkg::item_t               item,
	input  logic [rpwd_pkg::CFG_W-1:0]    timeout_ms,
	input  logic [rpwd_pkg::CFG_W-1:0]    failsafe_pulse,
	output logic                          has_result,
	output rpwd_pkg::result_t             result
);

	logic [rpwd_pkg::MS_W-1:0]    now_ms_q;
	logic                         awaiting_end_q    [rpwd_pkg::NUM_CHANNELS];
	logic [rpwd_pkg::PULSE_W-1:0] start_stamp_q     [rpwd_pkg::NUM_CHANNELS];
	logic [rpwd_pkg::PULSE_W-1:0] measured_length_q [rpwd_pkg::NUM_CHANNELS];
	logic [rpwd_pkg::MS_W-1:0]    last_update_ms_q  [rpwd_pkg::NUM_CHANNELS];

	logic                         is_edge, is_tick, is_read;
	logic                         chan_ok, servo_ok;
	logic [rpwd_pkg::PULSE_W-1:0] new_length;
	logic [rpwd_pkg::PULSE_W-1:0] servo_length;
	logic [rpwd_pkg::MS_W-1:0]    age_ms;
	logic                         fresh;

	always_comb begin
		is_edge = (item.kind == rpwd_pkg::KIND_EDGE);
		is_tick = (item.kind == rpwd_pkg::KIND_TICK);
		is_read = (item.kind == rpwd_pkg::KIND_READ);
		chan_ok  = (int'(item.channel) < rpwd_pkg::NUM_CHANNELS);
		servo_ok = chan_ok && (int'(item.channel) < rpwd_pkg::NUM_SERVOS);

		new_length = item.capture_value - start_stamp_q[item.channel];
		// An end edge reports the length it has just measured; a start edge
		// reports the length kept from the pulse before.
		servo_length = awaiting_end_q[item.channel] ? new_length
			: measured_length_q[item.channel];

		age_ms = now_ms_q - last_update_ms_q[item.channel];
		fresh  = (age_ms < {{(rpwd_pkg::MS_W-rpwd_pkg::CFG_W){1'b0}}, timeout_ms});

		has_result          = (is_edge && servo_ok) || is_read;
		result.target_index = item.channel;
		if (is_read) begin
			result.reply_kind  = rpwd_pkg::REPLY_READ;
			result.pulse_value = (chan_ok && fresh) ? measured_length_q[item.channel]
				: '0;
		end else begin
			result.reply_kind  = rpwd_pkg::REPLY_SERVO;
			result.pulse_value = (servo_length == '0) ? failsafe_pulse : servo_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_ms_q <= '0;
			for (int i = 0; i < rpwd_pkg::NUM_CHANNELS; i++) begin
				awaiting_end_q[i]    <= 1'b0;
				start_stamp_q[i]     <= '0;
				measured_length_q[i] <= '0;
				last_update_ms_q[i]  <= '0;
			end
		end else if (commit) begin
			if (is_tick) begin
				now_ms_q <= now_ms_q + 1'b1;
			end
			if (is_edge && chan_ok) begin
				if (awaiting_end_q[item.channel]) begin
					measured_length_q[item.channel] <= new_length;
					last_update_ms_q[item.channel]  <= now_ms_q;
					awaiting_end_q[item.channel]    <= 1'b0;
				end else begin
					start_stamp_q[item.channel]  <= item.capture_value;
					awaiting_end_q[item.channel] <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/rpwd_out_reg.sv =====
// ----------------------------------------------------------------------------
// RC pulse width decoder result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module rpwd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  rpwd_pkg::result_t data,
	output logic              free,
	rpwd_out_if.source        rsp
);

	logic              valid_q;
	rpwd_pkg::result_t data_q;

	// The register can take a new item when empty or when its item leaves now.
	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.reply_kind   = data_q.reply_kind;
	assign rsp.target_index = data_q.target_index;
	assign rsp.pulse_value  = data_q.pulse_value;

endmodule

// ===== hw/rtl/rc_pulse_width_decoder_core.sv =====
// ----------------------------------------------------------------------------
// RC pulse width decoder core
// Measures receiver pulse widths per channel, drives servo writes on every
// edge of a servo channel and answers read queries with the latest length or zero when stale.
// ----------------------------------------------------------------------------
//
//   Port      Direction  Protocol     Carries
//   req       in         valid/ready  kind, channel, capture_value
//   rsp       out        valid/ready  reply_kind, target_index, pulse_value
//   cfg_*     in         write only   timeout_ms (index 0), failsafe_pulse (1)
//
// Each item is held in the input register and, if it gives a result, moves on
// into the result register once that register has room for it. One item is
// accepted every cycle while the input register is not stalled; the channel
// register file is read and written in the same cycle that an item leaves the input register.
// Reset clears all channel state, the millisecond clock and both handshakes.
// When the result register is full and not being taken, an item that gives a
// result waits in the input register, and req.ready follows rsp.ready.
//
module rc_pulse_width_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	rpwd_in_if.sink                       req,
	rpwd_out_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [rpwd_pkg::CFG_W-1:0]    cfg_wdata
);

	// Configuration registers; the user must write them only while the block is idle (not enforced here).
	logic [rpwd_pkg::CFG_W-1:0] timeout_ms_q;
	logic [rpwd_pkg::CFG_W-1:0] failsafe_pulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ms_q     <= rpwd_pkg::TIMEOUT_MS_RST;
			failsafe_pulse_q <= rpwd_pkg::FAILSAFE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpwd_pkg::CFG_TIMEOUT:  timeout_ms_q     <= cfg_wdata;
				rpwd_pkg::CFG_FAILSAFE: failsafe_pulse_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register. An item leaves it when it gives no result, or when the
	// result register has room for its result.
	logic              item_v_s1;
	rpwd_pkg::item_t   item_s1;
	logic              has_result;
	logic              out_free;
	logic              advance;
	logic              accept;
	rpwd_pkg::result_t result;

	assign advance   = item_v_s1 && (!has_result || out_free);
	assign req.ready = !item_v_s1 || advance;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (accept) begin
			item_v_s1 <= 1'b1;
		end else if (advance) begin
			item_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind          <= req.kind;
			item_s1.channel       <= req.channel;
			item_s1.capture_value <= req.capture_value;
		end
	end

	// Channel state is updated in the cycle the item leaves the input
	// register, so the next item already sees the new state.
	rpwd_chan_regs u_chan_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.commit         (advance),
		.item           (item_s1),
		.timeout_ms     (timeout_ms_q),
		.failsafe_pulse (failsafe_pulse_q),
		.has_result     (has_result),
		.result         (result)
	);

	rpwd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && has_result),
		.data   (result),
		.free   (out_free),
		.rsp    (rsp)
	);

	// A result only appears after an item that gives one has been committed.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(advance && has_result))
		else $error("result valid without a committed item");

	// An item waiting for room in the result register blocks new input.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(item_v_s1 && has_result && !out_free) |-> !req.ready)
		else $error("input accepted while the input register is stalled");

	// A stalled item stays in the input register unchanged.
	a_stalled_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(item_v_s1 && !advance) |=> (item_v_s1 && $stable(item_s1)))
		else $error("stalled item lost or changed");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Pulse width decoder core testbench
// Drives capture edges, millisecond ticks and read queries into the decoder
// under several idling patterns and register settings. A model of
// the channel state predicts each servo write and read reply, and every
// returned item is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	// The fourth kind code has no package name; the block must ignore it.
	localparam logic [rpwd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	// Margin for items that give no result and are still passing through the
	// input register.
	localparam int SETTLE_CYCLES = 6;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [rpwd_pkg::CFG_W-1:0] cfg_wdata;

	rpwd_in_if  req_if();
	rpwd_out_if rsp_if();

	rc_pulse_width_decoder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted copy of the decoder state and its two registers.
	logic [rpwd_pkg::MS_W-1:0]    model_ms;
	logic                         pulse_open [rpwd_pkg::NUM_CHANNELS];
	logic [rpwd_pkg::PULSE_W-1:0] rise_stamp [rpwd_pkg::NUM_CHANNELS];
	logic [rpwd_pkg::PULSE_W-1:0] pulse_width [rpwd_pkg::NUM_CHANNELS];
	logic [rpwd_pkg::MS_W-1:0]    width_stamp_ms [rpwd_pkg::NUM_CHANNELS];
	logic [rpwd_pkg::CFG_W-1:0]   timeout_setting;
	logic [rpwd_pkg::CFG_W-1:0]   failsafe_setting;

	// Replies that the decoder still owes us, oldest first.
	rpwd_pkg::result_t expected_replies[$];

	int mismatch_count = 0;
	int cycle_count;
	int source_idle_pct = 0;
	int sink_stall_pct = 0;
	int holdoff_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Works out the reply, if any, that one accepted item causes, and moves the
	// predicted channel state on exactly as the decoder should.
	function automatic bit predict_reply(input logic [rpwd_pkg::KIND_W-1:0] kind,
			input logic [rpwd_pkg::CHAN_W-1:0] ch, input logic [rpwd_pkg::PULSE_W-1:0] cap,
			output rpwd_pkg::result_t reply);
		bit produced;
		produced = 1'b0;
		reply = '0;
		if (kind == rpwd_pkg::KIND_TICK) begin
			model_ms = model_ms + 1'b1;
		end else if (kind == rpwd_pkg::KIND_READ) begin
			// A read always answers; it carries the length only while fresh.
			reply.reply_kind   = rpwd_pkg::REPLY_READ;
			reply.target_index = ch;
			if (ch < rpwd_pkg::NUM_CHANNELS &&
					(model_ms - width_stamp_ms[ch]) < {16'd0, timeout_setting})
				reply.pulse_value = pulse_width[ch];
			produced = 1'b1;
		end else if (kind == rpwd_pkg::KIND_EDGE && ch < rpwd_pkg::NUM_CHANNELS) begin
			if (pulse_open[ch]) begin
				// End edge: the subtraction wraps through the timer rollover.
				pulse_width[ch]    = cap - rise_stamp[ch];
				width_stamp_ms[ch] = model_ms;
				pulse_open[ch]     = 1'b0;
			end else begin
				rise_stamp[ch] = cap;
				pulse_open[ch] = 1'b1;
			end
			// Both edges write the servo, using the kept length on a start edge.
			if (ch < rpwd_pkg::NUM_SERVOS) begin
				reply.reply_kind   = rpwd_pkg::REPLY_SERVO;
				reply.target_index = ch;
				reply.pulse_value  = (pulse_width[ch] == '0) ? failsafe_setting
					: pulse_width[ch];
				produced = 1'b1;
			end
		end
		return produced;
	endfunction

	// Offers one item, after an optional random idle gap, and holds it until the
	// decoder takes it. Valid stays high on return so that back-to-back items
	// never drop it in between.
	task automatic offer_request(input logic [rpwd_pkg::KIND_W-1:0] kind,
			input logic [rpwd_pkg::CHAN_W-1:0] ch, input logic [rpwd_pkg::PULSE_W-1:0] cap);
		rpwd_pkg::result_t reply;
		while ($urandom_range(0, 99) < source_idle_pct) begin
			@(negedge clk);
			req_if.valid         <= 1'b0;
			req_if.kind          <= rpwd_pkg::KIND_W'($urandom);
			req_if.channel       <= rpwd_pkg::CHAN_W'($urandom);
			req_if.capture_value <= rpwd_pkg::PULSE_W'($urandom);
		end
		@(negedge clk);
		req_if.valid         <= 1'b1;
		req_if.kind          <= kind;
		req_if.channel       <= ch;
		req_if.capture_value <= cap;
		do
			@(posedge clk);
		while (!req_if.ready);
		if (predict_reply(kind, ch, cap, reply))
			expected_replies.push_back(reply);
	endtask

	// Lowers valid and waits until every owed reply has come back, then lets the
	// pipeline settle so that no silent item is still in flight.
	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input rpwd_pkg::cfg_idx_t idx,
			input logic [rpwd_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == rpwd_pkg::CFG_TIMEOUT)
			timeout_setting = value;
		else
			failsafe_setting = value;
	endtask

	task automatic write_both_registers(input logic [rpwd_pkg::CFG_W-1:0] timeout,
			input logic [rpwd_pkg::CFG_W-1:0] failsafe);
		wait_drained();
		write_register(rpwd_pkg::CFG_TIMEOUT, timeout);
		write_register(rpwd_pkg::CFG_FAILSAFE, failsafe);
	endtask

	// Reset values, timer rollover in both directions, zero-length pulses,
	// channels that have no servo, the unused kind and a kept length on a
	// fresh start edge.
	task automatic test_directed_cases();
		offer_request(rpwd_pkg::KIND_READ, 3'd0, 16'h0000);
		offer_request(rpwd_pkg::KIND_READ, 3'd7, 16'hFFFF);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd0, 16'hFFFF);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd0, 16'h0000);
		offer_request(rpwd_pkg::KIND_READ, 3'd0, 16'h0000);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd1, 16'h0000);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd1, 16'hFFFF);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd2, 16'd1234);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd2, 16'd1234);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd6, 16'd100);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd7, 16'd200);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd6, 16'd1100);
		offer_request(rpwd_pkg::KIND_READ, 3'd6, 16'h0000);
		offer_request(KIND_UNUSED, 3'd5, 16'hFFFF);
		offer_request(rpwd_pkg::KIND_TICK, 3'd7, 16'hFFFF);
		offer_request(rpwd_pkg::KIND_READ, 3'd1, 16'h0000);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd0, 16'd500);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd5, 16'hAAAA);
		offer_request(rpwd_pkg::KIND_EDGE, 3'd5, 16'h5555);
		offer_request(rpwd_pkg::KIND_READ, 3'd5, 16'h0000);
		offer_request(rpwd_pkg::KIND_READ, 3'd7, 16'h0000);
	endtask

	// A zero timeout must make every read report zero; a timeout of one goes
	// stale after a single tick; the widest one never does in this run.
	task automatic test_register_extremes();
		logic [rpwd_pkg::CFG_W-1:0] timeouts [3] = '{16'd0, 16'd1, 16'hFFFF};
		logic [rpwd_pkg::CFG_W-1:0] failsafes [3] = '{16'd0, 16'hFFFF, 16'd1};
		for (int s = 0; s < 3; s++) begin
			write_both_registers(timeouts[s], failsafes[s]);
			offer_request(rpwd_pkg::KIND_EDGE, 3'd3, 16'd1000);
			offer_request(rpwd_pkg::KIND_EDGE, 3'd3, 16'd2500);
			offer_request(rpwd_pkg::KIND_READ, 3'd3, 16'h0000);
			offer_request(rpwd_pkg::KIND_TICK, 3'd0, 16'h0000);
			offer_request(rpwd_pkg::KIND_READ, 3'd3, 16'h0000);
			offer_request(rpwd_pkg::KIND_EDGE, 3'd4, 16'd777);
			offer_request(rpwd_pkg::KIND_EDGE, 3'd4, 16'd777);
			offer_request(rpwd_pkg::KIND_READ, 3'd4, 16'h0000);
		end
	endtask

	// Mostly well-formed pulses on random channels, so that end edges land a
	// plausible servo width after their start, mixed with ticks, reads, stray
	// edges with arbitrary timer values and the occasional unused kind.
	task automatic run_pulse_traffic(input int count);
		int pick;
		logic [rpwd_pkg::CHAN_W-1:0] ch;
		logic [rpwd_pkg::PULSE_W-1:0] cap;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			ch   = rpwd_pkg::CHAN_W'($urandom_range(0, rpwd_pkg::NUM_CHANNELS - 1));
			cap  = rpwd_pkg::PULSE_W'($urandom);
			if (pick < 45) begin
				if (pulse_open[ch]) begin
					if ($urandom_range(0, 19) == 0)
						cap = rise_stamp[ch];
					else if ($urandom_range(0, 9) != 0)
						cap = rpwd_pkg::PULSE_W'(rise_stamp[ch] + $urandom_range(800, 2200));
				end
				offer_request(rpwd_pkg::KIND_EDGE, ch, cap);
			end else if (pick < 70) begin
				offer_request(rpwd_pkg::KIND_TICK, ch, cap);
			end else if (pick < 95) begin
				offer_request(rpwd_pkg::KIND_READ, ch, cap);
			end else begin
				offer_request(KIND_UNUSED, ch, cap);
			end
		end
	endtask

	// The receiver refuses replies for a long stretch while the sender keeps
	// offering items that all give a reply, so the result register fills and the
	// decoder has to hold its input.
	task automatic test_backpressure();
		logic [rpwd_pkg::CHAN_W-1:0] ch;
		write_both_registers(16'd50, 16'd1500);
		source_idle_pct = 0;
		sink_stall_pct  = 0;
		@(posedge clk);
		holdoff_cycles = 300;
		for (int n = 0; n < 40; n++) begin
			ch = rpwd_pkg::CHAN_W'($urandom_range(0, rpwd_pkg::NUM_SERVOS - 1));
			if (n % 3 == 2)
				offer_request(rpwd_pkg::KIND_READ, ch, rpwd_pkg::PULSE_W'($urandom));
			else
				offer_request(rpwd_pkg::KIND_EDGE, ch, rpwd_pkg::PULSE_W'($urandom));
		end
	endtask

	// Four idling patterns, each with its own register setting.
	task automatic test_random_phases();
		write_both_registers(16'd50, 16'd1500);
		source_idle_pct = 0;
		sink_stall_pct  = 0;
		run_pulse_traffic(300);

		write_both_registers(16'd3, 16'd0);
		source_idle_pct = 81;
		sink_stall_pct  = 0;
		run_pulse_traffic(300);

		write_both_registers(16'hFFFF, 16'hFFFF);
		source_idle_pct = 0;
		sink_stall_pct  = 81;
		run_pulse_traffic(300);

		write_both_registers(16'd20, 16'd1000);
		source_idle_pct = 9;
		sink_stall_pct  = 9;
		run_pulse_traffic(300);
	endtask

	// Receiver side: random stalls, or a counted hold-off when one is asked for.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				holdoff_cycles--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	// Every reply taken is matched against the oldest prediction.
	always @(posedge clk) begin : check_replies
		rpwd_pkg::result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_replies.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected reply: expected none, actual %0d/%0d/%h",
					$time, rsp_if.reply_kind, rsp_if.target_index, rsp_if.pulse_value);
			end else begin
				want = expected_replies.pop_front();
				if (rsp_if.reply_kind !== want.reply_kind) begin
					mismatch_count++;
					$display("%0t: reply_kind: expected %0d, actual %0d",
						$time, want.reply_kind, rsp_if.reply_kind);
				end
				if (rsp_if.target_index !== want.target_index) begin
					mismatch_count++;
					$display("%0t: target_index: expected %0d, actual %0d",
						$time, want.target_index, rsp_if.target_index);
				end
				if (rsp_if.pulse_value !== want.pulse_value) begin
					mismatch_count++;
					$display("%0t: pulse_value: expected %h, actual %h",
						$time, want.pulse_value, rsp_if.pulse_value);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = rpwd_pkg::CFG_TIMEOUT;
		cfg_wdata            = '0;
		req_if.valid         = 1'b0;
		req_if.kind          = rpwd_pkg::KIND_EDGE;
		req_if.channel       = '0;
		req_if.capture_value = '0;

		model_ms         = '0;
		timeout_setting  = rpwd_pkg::TIMEOUT_MS_RST;
		failsafe_setting = rpwd_pkg::FAILSAFE_RST;
		for (int c = 0; c < rpwd_pkg::NUM_CHANNELS; c++) begin
			pulse_open[c]     = 1'b0;
			rise_stamp[c]     = '0;
			pulse_width[c]    = '0;
			width_stamp_ms[c] = '0;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_register_extremes();
		test_backpressure();
		test_random_phases();

		wait_drained();
		if (mismatch_count == 0 && expected_replies.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
